>>> rtl/order_statistic_multiset_unit_macros.svh
// assertion macros for the order statistic multiset unit
`ifndef ORDER_STATISTIC_MULTISET_UNIT_MACROS_SVH
`define ORDER_STATISTIC_MULTISET_UNIT_MACROS_SVH

// same-cycle implication, checked on clk with reset disabling
`define OSM_AST_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) else $error("osm check failed");

// next-cycle implication
`define OSM_AST_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error("osm check failed");

`endif

>>> rtl/osm_pkg.sv
// types and constants shared by the order statistic multiset unit
package osm_pkg;
	localparam int KEY_W    = 12;
	localparam int CNT_W    = 13;
	localparam int LEVELS   = KEY_W + 1;
	localparam int LEAVES   = 1 << KEY_W;
	localparam int CAPACITY = 4096;

	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_DELETE = 3'd1;
	localparam logic [2:0] MODE_RANK   = 3'd2;
	localparam logic [2:0] MODE_SELECT = 3'd3;
	localparam logic [2:0] MODE_PRED   = 3'd4;
	localparam logic [2:0] MODE_SUCC   = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PROBE, S_DECIDE, S_WALK} state_t;
	typedef enum logic [1:0] {PH_RANK, PH_PRED, PH_SUCC, PH_SELECT} phase_t;

	typedef struct packed {
		logic [2:0]          mode;
		logic signed [11:0]  key;
		logic [12:0]         position;
	} cmd_t;

	typedef struct packed {
		logic signed [11:0]  answer_key;
		logic [12:0]         answer_rank;
		logic                found;
		logic [1:0]          status;
	} result_t;

	// broadcast control to every level cell
	typedef struct packed {
		logic              clr;
		logic [KEY_W-1:0]  clr_addr;
		logic              write;
		logic              inc;
		logic [KEY_W-1:0]  ukey;
	} cell_ctl_t;

	// descent token handed from level to level
	typedef struct packed {
		logic              valid;
		logic              sel;
		logic [KEY_W-1:0]  prefix;
		logic [CNT_W-1:0]  k;
		logic [CNT_W-1:0]  sum;
		logic [KEY_W-1:0]  tgt;
	} tok_t;
endpackage

>>> rtl/osm_cell.sv
// one tree level: count memory plus one descent step
module osm_cell import osm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [3:0]       lvl,
	input  cell_ctl_t        ctl,
	input  tok_t             tok_in,
	output tok_t             tok_out,
	output logic [CNT_W-1:0] cnt
);
	logic [CNT_W-1:0] mem [LEAVES];
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       shamt;
	logic [KEY_W-1:0] addr_key, addr_tok, tgt_sh;
	tok_t             tok_s1, tok_q, tok_d;
	logic             dir;

	assign shamt    = 4'(KEY_W) - lvl;
	assign addr_key = ctl.ukey >> shamt;
	assign addr_tok = {tok_in.prefix[KEY_W-2:0], 1'b0};
	assign cnt      = cnt_q;
	assign tok_out  = tok_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			mem[ctl.clr_addr] <= '0;
		end else if (ctl.write) begin
			mem[addr_key] <= ctl.inc ? cnt_q + 1'b1 : cnt_q - 1'b1;
		end
		cnt_q <= mem[tok_in.valid ? addr_tok : addr_key];
	end

	// cnt_q now holds the left child count of the token's node
	always_comb begin
		tgt_sh = tok_s1.tgt >> shamt;
		dir    = tok_s1.sel ? (tok_s1.k > cnt_q) : tgt_sh[0];
		tok_d        = tok_s1;
		tok_d.prefix = {tok_s1.prefix[KEY_W-2:0], dir};
		if (tok_s1.sel && dir) begin
			tok_d.k = tok_s1.k - cnt_q;
		end
		if (!tok_s1.sel && dir) begin
			tok_d.sum = tok_s1.sum + cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_q  <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_q  <= tok_d;
		end
	end
endmodule

>>> rtl/order_statistic_multiset_unit.sv
// order statistic multiset: a counting tree held as a chain of level cells
// insert and delete update the count memories in the decide state; rank and select make one descent,
// predecessor and successor up to two descents, each level passing the token through tok_s1 and tok_q.
// one item at a time: busy stays high from the accepting edge until done.
// after reset the count memories are zeroed, one address a cycle,
// with busy high; done is a one-cycle strobe and cannot be stalled.
module order_statistic_multiset_unit import osm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);
	`include "order_statistic_multiset_unit_macros.svh"

	state_t           state_q, state_d;
	phase_t           phase_q, phase_d;
	logic [2:0]       mode_q;
	logic [KEY_W-1:0] u_q;
	logic [CNT_W-1:0] pos_q, total_q, total_d;
	logic [KEY_W-1:0] clr_q;
	tok_t             launch_q, launch_d, tok_idle;
	tok_t             tok_l [LEVELS+1];
	logic [CNT_W-1:0] cnt_l [LEVELS];
	cell_ctl_t        ctl;
	result_t          result_q, res_d;
	logic             done_q, done_d;
	logic [CNT_W-1:0] wsum;

	assign tok_idle = '0;
	assign tok_l[1] = launch_q;

	for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
		if (g == 0) begin : g_root
			osm_cell u_cell (.clk, .arst_n, .lvl(4'(g)), .ctl, .tok_in(tok_idle),
				.tok_out(tok_l[0]), .cnt(cnt_l[g]));
		end else begin : g_node
			osm_cell u_cell (.clk, .arst_n, .lvl(4'(g)), .ctl, .tok_in(tok_l[g]),
				.tok_out(tok_l[g+1]), .cnt(cnt_l[g]));
		end
	end

	assign wsum = tok_l[LEVELS].sum;

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		total_d  = total_q;
		launch_d = '0;
		res_d    = '0;
		done_d   = 1'b0;
		ctl      = '0;
		ctl.ukey     = u_q;
		ctl.clr_addr = clr_q;
		case (state_q)
			S_CLEAR: begin
				ctl.clr = 1'b1;
				if (clr_q == '1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_PROBE;
			end
			S_PROBE: state_d = S_DECIDE;
			S_DECIDE: begin
				total_d = cnt_l[0];
				state_d = S_IDLE;
				case (mode_q)
					MODE_INSERT: begin
						done_d = 1'b1;
						if (cnt_l[0] >= CNT_W'(CAPACITY)) res_d.status = ST_FULL;
						else begin
							ctl.write = 1'b1;
							ctl.inc   = 1'b1;
						end
					end
					MODE_DELETE: begin
						done_d = 1'b1;
						if (cnt_l[LEVELS-1] == '0) res_d.status = ST_ABSENT;
						else ctl.write = 1'b1;
					end
					MODE_RANK, MODE_PRED: begin
						launch_d.valid = 1'b1;
						launch_d.tgt   = u_q;
						phase_d = (mode_q == MODE_RANK) ? PH_RANK : PH_PRED;
						state_d = S_WALK;
					end
					MODE_SUCC: begin
						if (u_q == '1) done_d = 1'b1;
						else begin
							launch_d.valid = 1'b1;
							launch_d.tgt   = u_q + 1'b1;
							phase_d = PH_SUCC;
							state_d = S_WALK;
						end
					end
					MODE_SELECT: begin
						if (pos_q == '0 || pos_q > cnt_l[0]) done_d = 1'b1;
						else begin
							launch_d.valid = 1'b1;
							launch_d.sel   = 1'b1;
							launch_d.k     = pos_q;
							phase_d = PH_SELECT;
							state_d = S_WALK;
						end
					end
					default: done_d = 1'b1;
				endcase
			end
			S_WALK: begin
				if (tok_l[LEVELS].valid) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
					case (phase_q)
						PH_RANK: res_d.answer_rank = wsum + 1'b1;
						PH_PRED: begin
							if (wsum != '0) begin
								launch_d.valid = 1'b1;
								launch_d.sel   = 1'b1;
								launch_d.k     = wsum;
							end
						end
						PH_SUCC: begin
							if (wsum < total_q) begin
								launch_d.valid = 1'b1;
								launch_d.sel   = 1'b1;
								launch_d.k     = wsum + 1'b1;
							end
						end
						default: begin
							res_d.found      = 1'b1;
							res_d.answer_key = {~tok_l[LEVELS].prefix[KEY_W-1],
								tok_l[LEVELS].prefix[KEY_W-2:0]};
						end
					endcase
					if (launch_d.valid) begin
						done_d  = 1'b0;
						phase_d = PH_SELECT;
						state_d = S_WALK;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			done_q   <= 1'b0;
			launch_q <= '0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_q + 1'b1;
			done_q   <= done_d;
			launch_q <= launch_d;
		end
	end

	always_ff @(posedge clk) begin
		phase_q  <= phase_d;
		total_q  <= total_d;
		result_q <= res_d;
		if (start && state_q == S_IDLE) begin
			mode_q <= cmd.mode;
			u_q    <= {~cmd.key[KEY_W-1], cmd.key[KEY_W-2:0]};
			pos_q  <= cmd.position;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`OSM_AST_NEXT(a_start_busy, start && !busy, busy)
	`OSM_AST_IMPL(a_done_idle, done, !busy)
	`OSM_AST_IMPL(a_found_ok, done && result.found, result.status == ST_OK)
endmodule

>>> bench/order_statistic_multiset_checker.sv
// checker for the order statistic multiset unit: predicts each result and compares it
module order_statistic_multiset_checker import osm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	input  logic    busy,
	input  logic    done,
	input  result_t result,
	output int      errors,
	output int      pending,
	output int      stored_total,
	output int      results_seen
);
	int      mult [LEAVES];
	int      total;
	result_t expected_results [$];

	function automatic int count_below(int u);
		int s;
		s = 0;
		for (int j = 0; j < u; j++) s += mult[j];
		return s;
	endfunction

	// offset value of the k-th smallest stored key
	function automatic int select_kth(int k);
		int s;
		s = 0;
		for (int j = 0; j < LEAVES; j++) begin
			s += mult[j];
			if (s >= k) return j;
		end
		return 0;
	endfunction

	function automatic result_t predict_result(cmd_t c);
		result_t r;
		int u, cb, hit;
		logic have;
		r = '0;
		have = 1'b0;
		hit = 0;
		u = int'({~c.key[KEY_W-1], c.key[KEY_W-2:0]});
		case (c.mode)
			MODE_INSERT: begin
				if (total >= CAPACITY) r.status = ST_FULL;
				else begin
					mult[u]++;
					total++;
				end
			end
			MODE_DELETE: begin
				if (mult[u] == 0) r.status = ST_ABSENT;
				else begin
					mult[u]--;
					total--;
				end
			end
			MODE_RANK: r.answer_rank = CNT_W'(count_below(u) + 1);
			MODE_SELECT: begin
				if (c.position >= 1 && int'(c.position) <= total) begin
					hit = select_kth(int'(c.position));
					have = 1'b1;
				end
			end
			MODE_PRED: begin
				cb = count_below(u);
				if (cb > 0) begin
					hit = select_kth(cb);
					have = 1'b1;
				end
			end
			MODE_SUCC: begin
				cb = count_below(u) + mult[u];
				if (cb < total) begin
					hit = select_kth(cb + 1);
					have = 1'b1;
				end
			end
			default: ;
		endcase
		if (have) begin
			r.found = 1'b1;
			r.answer_key = {~hit[KEY_W-1], hit[KEY_W-2:0]};
		end
		return r;
	endfunction

	initial begin
		errors = 0;
		results_seen = 0;
		total = 0;
		for (int j = 0; j < LEAVES; j++) mult[j] = 0;
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result with no item outstanding");
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.answer_key !== want.answer_key) begin
						$error("answer_key expected %0d got %0d", want.answer_key,
							result.answer_key);
						errors++;
					end
					if (result.answer_rank !== want.answer_rank) begin
						$error("answer_rank expected %0d got %0d", want.answer_rank,
							result.answer_rank);
						errors++;
					end
					if (result.found !== want.found) begin
						$error("found expected %0b got %0b", want.found, result.found);
						errors++;
					end
					if (result.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, result.status);
						errors++;
					end
				end
			end
			if (start && !busy) expected_results.push_back(predict_result(cmd));
		end
	end

	assign pending = expected_results.size();
	assign stored_total = total;
endmodule

>>> bench/order_statistic_multiset_unit_test.sv
// stimulus and verdict for the order statistic multiset unit
module order_statistic_multiset_unit_test import osm_pkg::*;;
	logic    clk;
	logic    arst_n;
	logic    start;
	cmd_t    cmd;
	logic    busy;
	logic    done;
	result_t result;
	int      errors, pending, stored_total, results_seen;
	int      idle_pct;
	int      items_sent;
	logic signed [11:0] pool [16];

	order_statistic_multiset_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .result(result)
	);

	order_statistic_multiset_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.done(done), .result(result), .errors(errors), .pending(pending),
		.stored_total(stored_total), .results_seen(results_seen)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#30000000;
		$display("order_statistic_multiset_unit_test: errors");
		$finish;
	end

	// start stays high between back-to-back items
	task automatic send_item(logic [2:0] m, logic signed [11:0] k, logic [12:0] p);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		cmd <= '{mode: m, key: k, position: p};
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	function automatic logic signed [11:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 55) return pool[$urandom_range(15)];
		if (r < 65) return $urandom_range(1) ? 12'sh800 : 12'sh7ff;
		return 12'($urandom);
	endfunction

	function automatic logic [2:0] pick_mode();
		int r;
		r = $urandom_range(99);
		if (r < 30) return MODE_INSERT;
		if (r < 45) return MODE_DELETE;
		if (r < 58) return MODE_RANK;
		if (r < 73) return MODE_SELECT;
		if (r < 85) return MODE_PRED;
		if (r < 97) return MODE_SUCC;
		return 3'($urandom_range(7, 6));
	endfunction

	initial begin
		logic [12:0] p;
		int wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		idle_pct = 0;
		items_sent = 0;
		for (int j = 0; j < 16; j++) pool[j] = 12'($urandom);
		pool[0] = 12'sh800;
		pool[1] = 12'sh7ff;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, empty-store misses, absent delete, unused modes
		send_item(MODE_PRED, 12'sh000, 13'd0);
		send_item(MODE_SUCC, 12'sh000, 13'd0);
		send_item(MODE_SELECT, 12'sh000, 13'd1);
		send_item(MODE_DELETE, 12'sh800, 13'd0);
		send_item(MODE_INSERT, 12'sh800, 13'd0);
		send_item(MODE_INSERT, 12'sh7ff, 13'd0);
		send_item(MODE_INSERT, 12'sh000, 13'd0);
		send_item(MODE_INSERT, 12'shfff, 13'd0);
		send_item(MODE_INSERT, 12'sh000, 13'd0);
		send_item(MODE_RANK, 12'sh800, 13'd0);
		send_item(MODE_RANK, 12'sh7ff, 13'd0);
		send_item(MODE_SELECT, 12'sh000, 13'd0);
		send_item(MODE_SELECT, 12'sh000, 13'd5);
		send_item(MODE_SELECT, 12'sh000, 13'd6);
		send_item(MODE_SELECT, 12'sh000, 13'd4096);
		send_item(MODE_SELECT, 12'sh000, 13'h1fff);
		send_item(MODE_PRED, 12'sh800, 13'd0);
		send_item(MODE_PRED, 12'sh7ff, 13'd0);
		send_item(MODE_SUCC, 12'sh7ff, 13'd0);
		send_item(MODE_SUCC, 12'sh800, 13'd0);
		send_item(MODE_SUCC, 12'sh000, 13'd0);
		send_item(3'd6, 12'shfff, 13'h1fff);
		send_item(3'd7, 12'sh555, 13'h0aaa);
		send_item(MODE_DELETE, 12'sh000, 13'd0);
		send_item(MODE_DELETE, 12'sh123, 13'd0);

		// two inserts and three queries, then repeated deletes of the extreme keys and of 0 and -1 until the keys run out
		send_item(MODE_INSERT, 12'sh000, 13'd0);
		send_item(MODE_INSERT, 12'sh7ff, 13'd0);
		send_item(MODE_SELECT, 12'sh000, 13'd4096);
		send_item(MODE_RANK, 12'sh7ff, 13'd0);
		send_item(MODE_SUCC, 12'sh800, 13'd0);
		for (int j = 0; j < 16; j++) begin
			send_item(MODE_DELETE, 12'sh000, 13'd0);
			send_item(MODE_DELETE, 12'shfff, 13'd0);
			send_item(MODE_DELETE, 12'sh7ff, 13'd0);
			send_item(MODE_DELETE, 12'sh800, 13'd0);
		end

		// random phases: back to back, sender idle 46 and 33 percent
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 46 : 33;
			for (int j = 0; j < 400; j++) begin
				if ($urandom_range(3) == 0) p = 13'($urandom);
				else p = 13'($urandom_range(stored_total + 2));
				send_item(pick_mode(), pick_key(), p);
			end
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (60) @(posedge clk);
		$display("covered %0d items, %0d results, including edge keys and misses on an empty store",
			items_sent, results_seen);
		$display("random part mixed all six modes plus unused ones under three idle rates");
		if (errors == 0 && pending == 0)
			$display("order_statistic_multiset_unit_test: clean");
		else
			$display("order_statistic_multiset_unit_test: errors");
		$finish;
	end
endmodule
